### hdl/fic_pkg.sv
// ----------------------------------------------------------------------------
// fic_pkg
// Shared widths, reset values, register indexes and beat types for the
// flux interval capture block.
// ----------------------------------------------------------------------------
package fic_pkg;

    localparam int WORD_BITS          = 16;
    localparam int COUNTER_BITS_DEF   = 16;
    localparam int BUF_BITS           = 21;
    localparam int LIMIT_BITS         = 32;
    localparam int OFFSET_BITS        = 20;
    localparam int BYTE_BITS          = 8;
    localparam int CFG_INDEX_BITS     = 2;
    localparam int CFG_DATA_BITS      = 32;

    localparam logic [BUF_BITS-1:0]    BUFFER_BYTES_RST = BUF_BITS'(65536);
    localparam logic [LIMIT_BITS-1:0]  COUNT_LIMIT_RST  = '0;
    localparam logic                   RECORD_INDEX_RST = 1'b1;
    localparam logic [BYTE_BITS-1:0]   BYTE_MAX         = BYTE_BITS'(255);
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX       = '1;
    localparam logic [LIMIT_BITS-1:0]  TOTAL_MAX        = '1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BUFFER_BYTES = 2'd0,
        CFG_COUNT_LIMIT  = 2'd1,
        CFG_RECORD_INDEX = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [BUF_BITS-1:0]   buffer_bytes;
        logic [LIMIT_BITS-1:0] count_limit;
        logic                  record_index;
    } t_cfg;

    typedef struct packed {
        logic [WORD_BITS-1:0] counter_word;
        logic                 index_level;
        logic                 first_of_capture;
    } t_item;

    typedef struct packed {
        logic                   pulse_valid;
        logic [BYTE_BITS-1:0]   pulse_byte;
        logic                   index_hit;
        logic [OFFSET_BITS-1:0] index_offset;
        logic                   capture_done;
    } t_result;

endpackage

### hdl/fic_core.sv
// ----------------------------------------------------------------------------
// fic_core
// Capture state and the single-pass interval update: index edge check,
// modular difference, halving, byte saturation and running total.
// ----------------------------------------------------------------------------
module fic_core
    import fic_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [COUNTER_BITS-1:0] r_prev_word,  n_prev_word;
    logic                    r_prev_index, n_prev_index;
    logic [LIMIT_BITS-1:0]   r_total,      n_total;
    logic [BUF_BITS-1:0]     r_bytes,      n_bytes;
    logic                    r_primed,     n_primed;
    logic                    r_stopped,    n_stopped;

    logic [31:0]             w_word_ext;
    logic [COUNTER_BITS-1:0] w_word;
    logic [COUNTER_BITS-1:0] w_diff;
    logic [COUNTER_BITS-2:0] w_delta;
    logic [LIMIT_BITS:0]     w_sum;
    logic [LIMIT_BITS-1:0]   w_total_sat;
    logic [BUF_BITS-1:0]     w_bytes_inc;
    logic                    w_edge;

    assign w_word_ext  = {{(32-WORD_BITS){1'b0}}, i_item.counter_word};
    assign w_word      = w_word_ext[COUNTER_BITS-1:0];
    assign w_diff      = r_prev_word - w_word;
    assign w_delta     = w_diff[COUNTER_BITS-1:1];
    assign w_sum       = {1'b0, r_total} + (LIMIT_BITS+1)'(w_delta);
    assign w_total_sat = w_sum[LIMIT_BITS] ? TOTAL_MAX : w_sum[LIMIT_BITS-1:0];
    assign w_bytes_inc = r_bytes + BUF_BITS'(1);
    assign w_edge      = !i_item.index_level && r_prev_index && i_cfg.record_index;

    always_comb begin
        n_prev_word  = r_prev_word;
        n_prev_index = r_prev_index;
        n_total      = r_total;
        n_bytes      = r_bytes;
        n_primed     = r_primed;
        n_stopped    = r_stopped;
        o_result     = '0;

        if (i_item.first_of_capture) begin
            n_prev_word  = w_word;
            n_prev_index = i_item.index_level;
            n_total      = '0;
            n_bytes      = '0;
            n_primed     = 1'b1;
            n_stopped    = (i_cfg.buffer_bytes == '0);
        end else if (!r_stopped && r_primed) begin
            if (r_bytes >= i_cfg.buffer_bytes) begin
                n_stopped = 1'b1;
            end else begin
                n_prev_index = i_item.index_level;
                if (w_edge) begin
                    o_result.index_hit    = 1'b1;
                    o_result.index_offset = r_bytes[BUF_BITS-1] ? OFFSET_MAX
                                                                : r_bytes[OFFSET_BITS-1:0];
                end
                if (w_edge && (i_cfg.count_limit == '0)) begin
                    n_stopped = 1'b1;
                end else begin
                    n_prev_word          = w_word;
                    n_total              = w_total_sat;
                    n_bytes              = w_bytes_inc;
                    o_result.pulse_valid = 1'b1;
                    o_result.pulse_byte  = (32'(w_delta) > 32'(BYTE_MAX)) ? BYTE_MAX
                                                                          : BYTE_BITS'(w_delta);
                    if ((i_cfg.count_limit != '0) && (w_total_sat >= i_cfg.count_limit)) begin
                        n_stopped = 1'b1;
                    end
                    if (w_bytes_inc >= i_cfg.buffer_bytes) begin
                        n_stopped = 1'b1;
                    end
                end
            end
        end

        o_result.capture_done = n_stopped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_word  <= '0;
            r_prev_index <= 1'b0;
            r_total      <= '0;
            r_bytes      <= '0;
            r_primed     <= 1'b0;
            r_stopped    <= 1'b1;
        end else if (i_step) begin
            r_prev_word  <= n_prev_word;
            r_prev_index <= n_prev_index;
            r_total      <= n_total;
            r_bytes      <= n_bytes;
            r_primed     <= n_primed;
            r_stopped    <= n_stopped;
        end
    end

endmodule

### hdl/flux_interval_capture.sv
// An accepted input beat is held in the input register, its result beat in the
// result register. Throughput: one beat per cycle while the output is ready; the
// two registers decouple the sides and the capture state updates between them.
// Reset (synchronous, active low) empties both registers, clears the capture
// state to idle-stopped and loads the default configuration.
// ----------------------------------------------------------------------------
// flux_interval_capture
// Turns captured flux down-counter words into at most one interval byte per beat,
// with index edge reporting and limit, index or buffer-full stop.
// ----------------------------------------------------------------------------
module flux_interval_capture
    import fic_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,

    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [WORD_BITS-1:0]      i_counter_word,
    input  logic                      i_index_level,
    input  logic                      i_first_of_capture,

    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_pulse_valid,
    output logic [BYTE_BITS-1:0]      o_pulse_byte,
    output logic                      o_index_hit,
    output logic [OFFSET_BITS-1:0]    o_index_offset,
    output logic                      o_capture_done
);

    t_cfg    r_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result w_result;
    logic    w_out_free;
    logic    w_step;
    logic    w_in_take;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;
    assign w_in_take  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buffer_bytes <= BUFFER_BYTES_RST;
            r_cfg.count_limit  <= COUNT_LIMIT_RST;
            r_cfg.record_index <= RECORD_INDEX_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BUFFER_BYTES: r_cfg.buffer_bytes <= i_cfg_data[BUF_BITS-1:0];
                CFG_COUNT_LIMIT:  r_cfg.count_limit  <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_RECORD_INDEX: r_cfg.record_index <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_take || (r_in_valid && !w_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.counter_word     <= i_counter_word;
            r_in.index_level      <= i_index_level;
            r_in.first_of_capture <= i_first_of_capture;
        end
    end

    fic_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_step || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pulse_valid  = r_out.pulse_valid;
    assign o_pulse_byte   = r_out.pulse_byte;
    assign o_index_hit    = r_out.index_hit;
    assign o_index_offset = r_out.index_offset;
    assign o_capture_done = r_out.capture_done;

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("processed beat did not reach the result register");

    a_take_fills_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> r_in_valid)
        else $error("accepted beat lost from the input register");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_pulse_valid) |-> (o_pulse_byte == '0))
        else $error("pulse byte set without a pulse");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_index_hit) |-> (o_index_offset == '0))
        else $error("index offset set without an index hit");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for flux_interval_capture: a queue-fed driver offers
// counter-word beats, a clocked monitor compares every result beat with the
// interval and index prediction made at input acceptance.
// ----------------------------------------------------------------------------
module tb;
    import fic_pkg::*;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [WORD_BITS-1:0]      counter_word = '0;
    logic                      index_level = 1'b0;
    logic                      first_of_capture = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      pulse_valid;
    logic [BYTE_BITS-1:0]      pulse_byte;
    logic                      index_hit;
    logic [OFFSET_BITS-1:0]    index_offset;
    logic                      capture_done;

    flux_interval_capture DUT (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_counter_word     (counter_word),
        .i_index_level      (index_level),
        .i_first_of_capture (first_of_capture),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_pulse_valid      (pulse_valid),
        .o_pulse_byte       (pulse_byte),
        .o_index_hit        (index_hit),
        .o_index_offset     (index_offset),
        .o_capture_done     (capture_done)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of configuration and capture state
    logic [BUF_BITS-1:0]   cfg_buffer_bytes = BUFFER_BYTES_RST;
    logic [LIMIT_BITS-1:0] cfg_count_limit  = COUNT_LIMIT_RST;
    logic                  cfg_record_index = RECORD_INDEX_RST;
    logic [WORD_BITS-1:0]  prev_word = '0;
    logic                  prev_index = 1'b0;
    logic [LIMIT_BITS-1:0] total_count = '0;
    logic [BUF_BITS-1:0]   bytes_written = '0;
    logic                  primed = 1'b0;
    logic                  stopped = 1'b1;

    t_item   pending_words[$];
    t_result expected_beats[$];
    logic    in_busy = 1'b0;
    int      idle_pct = 33;
    logic    rx_hold_req = 1'b0;
    int      rx_hold_left = 0;
    int      n_mismatch = 0;
    int      n_queued = 0;

    function automatic t_result advance_capture(t_item it);
        t_result              r;
        logic [WORD_BITS-1:0] diff;
        logic [WORD_BITS-1:0] delta;
        logic [LIMIT_BITS:0]  sum;
        logic                 stop_now;
        r = '0;
        if (it.first_of_capture) begin
            prev_word     = it.counter_word;
            prev_index    = it.index_level;
            total_count   = '0;
            bytes_written = '0;
            primed        = 1'b1;
            stopped       = (cfg_buffer_bytes == '0);
        end else if (!stopped && primed) begin
            if (bytes_written >= cfg_buffer_bytes) begin
                stopped = 1'b1;
            end else begin
                stop_now = 1'b0;
                if (!it.index_level && prev_index && cfg_record_index) begin
                    r.index_hit    = 1'b1;
                    r.index_offset = (bytes_written > BUF_BITS'(OFFSET_MAX)) ?
                                     OFFSET_MAX : bytes_written[OFFSET_BITS-1:0];
                    if (cfg_count_limit == '0)
                        stop_now = 1'b1;
                end
                prev_index = it.index_level;
                if (stop_now) begin
                    stopped = 1'b1;
                end else begin
                    diff          = prev_word - it.counter_word;
                    delta         = diff >> 1;
                    sum           = {1'b0, total_count} + (LIMIT_BITS + 1)'(delta);
                    prev_word     = it.counter_word;
                    total_count   = sum[LIMIT_BITS] ? TOTAL_MAX : sum[LIMIT_BITS-1:0];
                    r.pulse_valid = 1'b1;
                    r.pulse_byte  = (delta > WORD_BITS'(BYTE_MAX)) ?
                                    BYTE_MAX : delta[BYTE_BITS-1:0];
                    bytes_written = bytes_written + 1'b1;
                    if (cfg_count_limit != '0 && total_count >= cfg_count_limit)
                        stopped = 1'b1;
                    if (bytes_written >= cfg_buffer_bytes)
                        stopped = 1'b1;
                end
            end
        end
        r.capture_done = stopped;
        return r;
    endfunction

    task automatic note_error(string msg);
        if (n_mismatch < 10)
            $display("[%0t] %s", $realtime, msg);
        n_mismatch++;
    endtask

    // driver: offer the next pending beat, hold it until taken
    always @(negedge clk) begin
        t_item it;
        if (rst_n && !in_busy) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
                it               = pending_words.pop_front();
                counter_word     <= it.counter_word;
                index_level      <= it.index_level;
                first_of_capture <= it.first_of_capture;
                in_valid         <= 1'b1;
                in_busy          = 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        t_item it;
        if (rst_n && in_valid && in_ready) begin
            it.counter_word     = counter_word;
            it.index_level      = index_level;
            it.first_of_capture = first_of_capture;
            expected_beats.push_back(advance_capture(it));
            in_busy = 1'b0;
        end
    end

    // receiver ready, with a counted hold-off on request
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (rx_hold_req) begin
                rx_hold_left = 400;
                rx_hold_req  = 1'b0;
            end
            if (rx_hold_left > 0) begin
                out_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_beats.size() == 0) begin
                note_error($sformatf({"unexpected result beat",
                                      " valid=%0b byte=%0d hit=%0b off=%0d done=%0b"},
                                     pulse_valid, pulse_byte, index_hit, index_offset,
                                     capture_done));
            end else begin
                want = expected_beats.pop_front();
                if (pulse_valid !== want.pulse_valid || pulse_byte !== want.pulse_byte ||
                    index_hit !== want.index_hit || index_offset !== want.index_offset ||
                    capture_done !== want.capture_done)
                    note_error($sformatf({"mismatch exp valid=%0b byte=%0d hit=%0b off=%0d done=%0b",
                                          " got valid=%0b byte=%0d hit=%0b off=%0d done=%0b"},
                                         want.pulse_valid, want.pulse_byte, want.index_hit,
                                         want.index_offset, want.capture_done,
                                         pulse_valid, pulse_byte, index_hit, index_offset,
                                         capture_done));
            end
        end
    end

    task automatic push_word(logic [WORD_BITS-1:0] w, logic lvl, logic first);
        t_item it;
        it.counter_word     = w;
        it.index_level      = lvl;
        it.first_of_capture = first;
        pending_words.push_back(it);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BUFFER_BYTES: cfg_buffer_bytes = val[BUF_BITS-1:0];
            CFG_COUNT_LIMIT:  cfg_count_limit  = val[LIMIT_BITS-1:0];
            CFG_RECORD_INDEX: cfg_record_index = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(logic [CFG_DATA_BITS-1:0] buf_bytes,
                              logic [CFG_DATA_BITS-1:0] limit, logic rec);
        write_reg(CFG_BUFFER_BYTES, buf_bytes);
        write_reg(CFG_COUNT_LIMIT, limit);
        write_reg(CFG_RECORD_INDEX, CFG_DATA_BITS'(rec));
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || in_busy || expected_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one well-formed capture: a priming word and n counter words, mostly decreasing
    task automatic queue_capture(int n_words);
        logic [WORD_BITS-1:0] w;
        logic                 lvl;
        w   = WORD_BITS'($urandom);
        lvl = 1'($urandom_range(1));
        push_word(w, lvl, 1'b1);
        repeat (n_words) begin
            case ($urandom_range(9))
                0:       w = w - WORD_BITS'($urandom_range(3));
                7:       w = w - WORD_BITS'($urandom_range(65535, 600));
                8:       w = WORD_BITS'($urandom);
                default: w = w - WORD_BITS'($urandom_range(600, 40));
            endcase
            if ($urandom_range(7) == 0)
                lvl = ~lvl;
            push_word(w, lvl, 1'b0);
        end
        n_queued += n_words + 1;
    endtask

    task automatic queue_phase(int target);
        int goal;
        int n_burst;
        goal = n_queued + target;
        while (n_queued < goal) begin
            if ($urandom_range(9) == 0) begin
                n_burst = $urandom_range(5, 1);
                repeat (n_burst)
                    push_word(WORD_BITS'($urandom), 1'($urandom_range(1)),
                              ($urandom_range(9) == 0));
                n_queued += n_burst;
            end else begin
                queue_capture($urandom_range(40, 1));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default setup: index edge ends the capture
        push_word(16'hFFFF, 1'b1, 1'b0);
        push_word(16'hFFFF, 1'b0, 1'b1);
        push_word(16'hFFFF, 1'b1, 1'b0);
        push_word(16'hFFFD, 1'b1, 1'b0);
        push_word(16'hFE00, 1'b1, 1'b0);
        push_word(16'hFC00, 1'b1, 1'b0);
        push_word(16'h0000, 1'b1, 1'b0);
        push_word(16'h0010, 1'b1, 1'b0);
        push_word(16'h0008, 1'b0, 1'b0);
        push_word(16'h0000, 1'b0, 1'b0);
        wait_idle();

        // edges tracked but not reported
        set_config(32'd65536, '0, 1'b0);
        push_word(16'h1234, 1'b1, 1'b1);
        push_word(16'h1230, 1'b0, 1'b0);
        push_word(16'h1200, 1'b1, 1'b0);
        wait_idle();

        // edge reported with a limit set, then the limit stops
        set_config(32'd65536, 32'd100, 1'b1);
        push_word(16'h8000, 1'b1, 1'b1);
        push_word(16'h7F00, 1'b0, 1'b0);
        push_word(16'h7E00, 1'b0, 1'b0);
        wait_idle();

        // buffer fills
        set_config(32'd3, '0, 1'b0);
        push_word(16'h4000, 1'b0, 1'b1);
        push_word(16'h3FF0, 1'b0, 1'b0);
        push_word(16'h3FE0, 1'b0, 1'b0);
        push_word(16'h3FD0, 1'b0, 1'b0);
        push_word(16'h3FC0, 1'b0, 1'b0);
        wait_idle();

        // buffer lowered below the bytes already written
        write_reg(CFG_BUFFER_BYTES, 32'd10);
        push_word(16'h2000, 1'b1, 1'b1);
        push_word(16'h1FF0, 1'b1, 1'b0);
        push_word(16'h1FE0, 1'b1, 1'b0);
        push_word(16'h1FD0, 1'b1, 1'b0);
        wait_idle();
        write_reg(CFG_BUFFER_BYTES, 32'd2);
        push_word(16'h1FC0, 1'b1, 1'b0);
        wait_idle();

        // zero budget stops at the priming word
        write_reg(CFG_BUFFER_BYTES, '0);
        push_word(16'h5555, 1'b0, 1'b1);
        push_word(16'h5550, 1'b0, 1'b0);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_config(32'd65536, '0, 1'b1);
                1: set_config($urandom_range(48, 1), '0, 1'b0);
                2: set_config(32'd1048576, 32'hFFFF_FFFF, 1'b1);
                3: set_config(32'd1, $urandom, 1'($urandom_range(1)));
                4: set_config($urandom_range(200, 16), $urandom_range(30000, 1), 1'b1);
                5: set_config($urandom_range(64, 2), 32'd1, 1'b0);
                6: set_config($urandom_range(1048576, 1), $urandom_range(60000, 1000), 1'b1);
                default: set_config($urandom_range(100, 1), '0, 1'b1);
            endcase
            idle_pct = (p == 2) ? 0 : 33;
            if (p == 4)
                rx_hold_req = 1'b1;
            queue_phase(36);
            if (p == 5)
                wait_idle();
            queue_phase(36);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (expected_beats.size() != 0)
            note_error($sformatf("%0d result beats never arrived", expected_beats.size()));
        if (n_mismatch == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
